[src/vps_pkg.sv]
package vps_pkg;

	localparam int BOUNCE_FRAC = 16;

	localparam logic [1:0] OP_LOAD_FORCE = 2'd0;
	localparam logic [1:0] OP_LOAD_POS   = 2'd1;
	localparam logic [1:0] OP_STEP       = 2'd2;

	localparam logic [2:0] REG_INV_MASS  = 3'd0;
	localparam logic [2:0] REG_RADIUS    = 3'd1;
	localparam logic [2:0] REG_HALF_SIZE = 3'd2;
	localparam logic [2:0] REG_BOUNCE    = 3'd3;
	localparam logic [2:0] REG_TIME_STEP = 3'd4;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [30:0] inverse_mass;
		logic [30:0] sphere_radius;
		logic [30:0] box_half_size;
		logic [16:0] bounce_factor;
		logic [30:0] time_step;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > SAT_MAX) begin
			return 32'sh7fffffff;
		end else if (v < SAT_MIN) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

[src/vps_cfg.sv]
module vps_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [30:0]   cfg_data,
	output vps_pkg::cfg_t cfg
);
	import vps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inverse_mass  <= 31'd65536;
			cfg_q.sphere_radius <= 31'd6554;
			cfg_q.box_half_size <= 31'd65536;
			cfg_q.bounce_factor <= 17'd42598;
			cfg_q.time_step     <= 31'd1092;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INV_MASS:  cfg_q.inverse_mass  <= cfg_data;
				REG_RADIUS:    cfg_q.sphere_radius <= cfg_data;
				REG_HALF_SIZE: cfg_q.box_half_size <= cfg_data;
				REG_BOUNCE:    cfg_q.bounce_factor <= cfg_data[16:0];
				REG_TIME_STEP: cfg_q.time_step     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/vps_mul.sv]
module vps_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

[src/verlet_particle_step_with_walls.sv]
// One particle in a cube with bouncing walls, integrated by position Verlet in signed
// fixed point with FRAC_BITS fraction bits. A load word goes from idle straight to the done
// state. A step word goes through the axes one after another on a single shared 32 by 32
// multiplier: three multiplications per axis (acceleration, times dt, times dt), plus a
// fourth, used only when the axis hits a wall, to scale the reflected force; each axis
// passes the states MUL_A, MUL_1, MUL_2 and UPD, and BNC after a wall hit. The input is
// ready again when the sequencer is idle and the output register is empty or its word is
// taken in the same cycle.
module verlet_particle_step_with_walls #(
	parameter int FRAC_BITS = 16,
	parameter int AXES      = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	input  logic signed [31:0] value_z,
	input  logic signed [31:0] drag_in_x,
	input  logic signed [31:0] drag_in_y,
	input  logic signed [31:0] drag_in_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_out_x,
	output logic signed [31:0] pos_out_y,
	output logic signed [31:0] pos_out_z,
	output logic               wall_hit_x,
	output logic               wall_hit_y,
	output logic               wall_hit_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data
);
	import vps_pkg::*;

	localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL_A = 3'd1;
	localparam logic [2:0] ST_MUL_1 = 3'd2;
	localparam logic [2:0] ST_MUL_2 = 3'd3;
	localparam logic [2:0] ST_UPD   = 3'd4;
	localparam logic [2:0] ST_BNC   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	cfg_t cfg;

	logic [2:0]         state_q;
	logic [AXW-1:0]     axis_q;
	logic [2:0]         hit_q;
	logic signed [31:0] cur_q   [AXES];
	logic signed [31:0] prev_q  [AXES];
	logic signed [31:0] force_q [AXES];
	logic signed [31:0] drag_q  [AXES];

	logic               out_valid_q;
	logic signed [31:0] out_pos_q [3];
	logic [2:0]         out_hit_q;

	logic signed [31:0] val_in  [3];
	logic signed [31:0] drag_in [3];

	logic               mul_en;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod_q;

	logic signed [31:0] sum_w;
	logic signed [31:0] scaled_w;
	logic signed [31:0] bnc_w;
	logic signed [31:0] np_w;
	logic signed [31:0] drag_neg_w;
	logic signed [33:0] hi_w;
	logic signed [33:0] lo_w;
	logic signed [33:0] half_w;
	logic signed [33:0] rad_w;
	logic               hit_w;
	logic               last_w;
	logic               accept;

	vps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vps_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign val_in[0]  = value_x;
	assign val_in[1]  = value_y;
	assign val_in[2]  = value_z;
	assign drag_in[0] = drag_in_x;
	assign drag_in[1] = drag_in_y;
	assign drag_in[2] = drag_in_z;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign last_w   = (axis_q == AXW'(AXES - 1));

	always_comb begin
		sum_w      = sat32(64'(drag_q[axis_q]) + 64'(force_q[axis_q]));
		scaled_w   = sat32(prod_q >>> FRAC_BITS);
		bnc_w      = sat32((-prod_q) >>> BOUNCE_FRAC);
		np_w       = sat32((64'(cur_q[axis_q]) <<< 1) - 64'(prev_q[axis_q]) + 64'(scaled_w));
		drag_neg_w = sat32(-64'(drag_q[axis_q]));
		rad_w      = $signed({3'b000, cfg.sphere_radius});
		half_w     = $signed({3'b000, cfg.box_half_size});
		hi_w       = 34'(np_w) + rad_w;
		lo_w       = 34'(np_w) - rad_w;
		hit_w      = (hi_w >= half_w) || (lo_w <= -half_w);
	end

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_MUL_A: begin
				mul_a = sum_w;
				mul_b = $signed({1'b0, cfg.inverse_mass});
			end
			ST_MUL_1, ST_MUL_2: begin
				mul_a = scaled_w;
				mul_b = $signed({1'b0, cfg.time_step});
			end
			ST_UPD: begin
				mul_a = force_q[axis_q];
				mul_b = $signed({15'd0, cfg.bounce_factor});
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			hit_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				cur_q[i]   <= '0;
				prev_q[i]  <= '0;
				force_q[i] <= '0;
				drag_q[i]  <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q  <= '0;
						axis_q <= '0;
						unique case (opcode)
							OP_LOAD_FORCE: begin
								for (int i = 0; i < AXES; i++) begin
									force_q[i] <= val_in[i];
									drag_q[i]  <= drag_in[i];
								end
								state_q <= ST_DONE;
							end
							OP_LOAD_POS: begin
								for (int i = 0; i < AXES; i++) begin
									cur_q[i]  <= val_in[i];
									prev_q[i] <= val_in[i];
								end
								state_q <= ST_DONE;
							end
							OP_STEP: state_q <= ST_MUL_A;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_MUL_A: state_q <= ST_MUL_1;
				ST_MUL_1: state_q <= ST_MUL_2;
				ST_MUL_2: state_q <= ST_UPD;
				ST_UPD: begin
					prev_q[axis_q] <= cur_q[axis_q];
					if (hit_w) begin
						drag_q[axis_q] <= drag_neg_w;
						hit_q[axis_q]  <= 1'b1;
						state_q        <= ST_BNC;
					end else begin
						cur_q[axis_q] <= np_w;
						if (last_w) begin
							state_q <= ST_DONE;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= ST_MUL_A;
						end
					end
				end
				ST_BNC: begin
					force_q[axis_q] <= bnc_w;
					if (last_w) begin
						state_q <= ST_DONE;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_MUL_A;
					end
				end
				ST_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			for (int i = 0; i < 3; i++) begin
				if (i < AXES) begin
					out_pos_q[i] <= cur_q[i];
					out_hit_q[i] <= hit_q[i];
				end else begin
					out_pos_q[i] <= '0;
					out_hit_q[i] <= 1'b0;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pos_out_x  = out_pos_q[0];
	assign pos_out_y  = out_pos_q[1];
	assign pos_out_z  = out_pos_q[2];
	assign wall_hit_x = out_hit_q[0];
	assign wall_hit_y = out_hit_q[1];
	assign wall_hit_z = out_hit_q[2];

endmodule
